@@ src/insort_pkg.sv @@
package insort_pkg;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic load;
        logic drop;
        logic rd_prev;
        logic shift;
        logic place;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_one;
        logic greater;
        logic last;
        logic final_k;
    } status_t;

endpackage

@@ src/insertion_sorter_unit.sv @@
// Insertion: busy stays high while the value is shifted past the larger stored entries and placed
// (low for a dropped value that does not end a set), at most one store read and write per cycle.
// A set of N entries then emits N results on consecutive cycles, the first after the controller
// enters its emit state and registers valid; the receiver cannot stall, valid marks each result.
// Reset (rst_n low, async) clears the entry count, internal drop flag, valid strobe and controller;
// the store contents stay undefined and are never read before being written.
module insertion_sorter_unit #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [insort_pkg::DATA_W-1:0]  value,
    input  logic                                  last_in,
    output logic                                  valid,
    output logic signed [insort_pkg::DATA_W-1:0]  sorted_value,
    output logic                                  last_out,
    output logic                                  overflow
);

    insort_pkg::cmd_t    cmd;
    insort_pkg::status_t status;

    insort_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last_in (last_in),
        .busy    (busy),
        .cmd     (cmd),
        .status  (status)
    );

    insort_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .last_in      (last_in),
        .cmd          (cmd),
        .status       (status),
        .valid        (valid),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

`ifndef SYNTHESIS
    a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> valid)
        else $error("emit transaction without result strobe");

    a_set_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last_out) |=> !valid)
        else $error("result strobe after final result of set");

    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.shift, cmd.place, cmd.emit}))
        else $error("store access conflict");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(cmd.shift || cmd.place || cmd.emit || cmd.rd_prev))
        else $error("store access while idle");
`endif

endmodule

@@ src/insort_ram.sv @@
module insort_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/insort_ctrl.sv @@
module insort_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 last_in,
    output logic                 busy,
    output insort_pkg::cmd_t     cmd,
    input  insort_pkg::status_t  status
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CMP   = 5'b00100,
        S_PLACE = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.full)
                    begin
                        cmd.drop = 1'b1;
                        if (last_in)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else if (status.empty)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (status.greater)
                begin
                    cmd.shift = 1'b1;
                    if (status.pos_one)
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = status.last ? S_EMIT : S_IDLE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.final_k)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ src/insort_datapath.sv @@
module insort_datapath #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [insort_pkg::DATA_W-1:0] value,
    input  logic                              last_in,
    input  insort_pkg::cmd_t                  cmd,
    output insort_pkg::status_t               status,
    output logic                              valid,
    output logic signed [insort_pkg::DATA_W-1:0] sorted_value,
    output logic                              last_out,
    output logic                              overflow
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [insort_pkg::DATA_W-1:0] value_reg;
    logic                          last_reg;
    logic [AW-1:0]                 pos_reg;
    logic [AW-1:0]                 pos_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          dropped_reg;
    logic                          dropped_next;
    logic [AW-1:0]                 k_reg;
    logic [AW-1:0]                 k_next;
    logic                          valid_reg;
    logic                          last_out_reg;
    logic                          ovf_reg;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [insort_pkg::DATA_W-1:0] ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [insort_pkg::DATA_W-1:0] ram_rdata;

    insort_ram #(
        .WIDTH (insort_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pos_next     = pos_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        k_next       = k_reg;
        if (cmd.load)
        begin
            pos_next = count_reg[AW-1:0];
            k_next   = '0;
        end
        if (cmd.shift)
        begin
            pos_next = pos_reg - AW'(1);
        end
        if (cmd.place)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.emit)
        begin
            k_next = k_reg + AW'(1);
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        if (cmd.finish)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_comb
    begin
        ram_we    = cmd.shift | cmd.place;
        ram_waddr = pos_reg;
        ram_wdata = cmd.shift ? ram_rdata : value_reg;
        ram_re    = cmd.rd_prev | (cmd.shift & ~status.pos_one) | cmd.emit;
        priority if (cmd.emit)
        begin
            ram_raddr = k_reg;
        end
        else if (cmd.shift)
        begin
            ram_raddr = pos_reg - AW'(2);
        end
        else
        begin
            ram_raddr = pos_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            valid_reg   <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            last_reg  <= last_in;
        end
        pos_reg <= pos_next;
        k_reg   <= k_next;
        if (cmd.emit)
        begin
            last_out_reg <= status.final_k;
            ovf_reg      <= dropped_reg;
        end
    end

    assign status.full    = (count_reg == CW'(DEPTH));
    assign status.empty   = (count_reg == '0);
    assign status.pos_one = (pos_reg == AW'(1));
    assign status.greater = ($signed(ram_rdata) > $signed(value_reg));
    assign status.last    = last_reg;
    assign status.final_k = ((CW'(k_reg) + CW'(1)) == count_reg);

    assign valid        = valid_reg;
    assign sorted_value = ram_rdata;
    assign last_out     = last_out_reg;
    assign overflow     = ovf_reg;

endmodule

@@ tb/insertion_sorter_unit_tb.sv @@
`timescale 1ns / 100ps
module insertion_sorter_unit_tb;

    localparam int unsigned DEPTH = 64;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP = 40;
    localparam int REPORT_LIMIT = 10;
    localparam logic signed [insort_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(insort_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [insort_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(insort_pkg::DATA_W-1){1'b1}}};

    typedef struct {
        logic signed [insort_pkg::DATA_W-1:0] sorted_value;
        logic                                 last_out;
        logic                                 overflow;
    } sorted_result_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [insort_pkg::DATA_W-1:0] value;
    logic                                 last_in;
    logic                                 valid;
    logic signed [insort_pkg::DATA_W-1:0] sorted_value;
    logic                                 last_out;
    logic                                 overflow;

    sorted_result_t                       expected_results[$];
    sorted_result_t                       oldest_result;
    logic signed [insort_pkg::DATA_W-1:0] shadow_store[$];
    bit                                   shadow_dropped;
    bit                                   sending;
    int                                   mismatch_count;
    int                                   sender_idle_pct;
    int                                   idle_cycles;

    insertion_sorter_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .last_in(last_in),
        .valid(valid),
        .sorted_value(sorted_value),
        .last_out(last_out),
        .overflow(overflow)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void predict_sorted(input logic signed [insort_pkg::DATA_W-1:0] v,
                                           input logic l);
        int             pos;
        sorted_result_t r;
        if (shadow_store.size() >= DEPTH)
        begin
            shadow_dropped = 1'b1;
        end
        else
        begin
            pos = shadow_store.size();
            while (pos > 0 && shadow_store[pos-1] > v)
                pos--;
            shadow_store.insert(pos, v);
        end
        if (l)
        begin
            foreach (shadow_store[i])
            begin
                r.sorted_value = shadow_store[i];
                r.last_out     = (i == shadow_store.size() - 1);
                r.overflow     = shadow_dropped;
                expected_results.push_back(r);
            end
            shadow_store.delete();
            shadow_dropped = 1'b0;
        end
    endfunction

    function automatic logic signed [insort_pkg::DATA_W-1:0] random_value();
        logic signed [insort_pkg::DATA_W-1:0] v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(15)) - 8;
            1:
            begin
                case ($urandom_range(3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic signed [insort_pkg::DATA_W-1:0] v, input logic l);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            if (sending)
                start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        last_in <= l;
        sending = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_sorted(v, l);
    endtask

    task automatic wait_drain();
        if (sending)
        begin
            start <= 1'b0;
            sending = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        sender_idle_pct = 14;
        send_value('0, 1'b1);
        send_value(VAL_MAX, 1'b0);
        send_value(VAL_MIN, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value('0, 1'b0);
        send_value(VAL_MIN, 1'b0);
        send_value(VAL_MAX, 1'b1);
        for (int i = 5; i >= 1; i--)
            send_value(i, i == 1);
        for (int i = 0; i < 3; i++)
            send_value(-5, i == 2);
        send_value(VAL_MIN, 1'b1);
        send_value(VAL_MAX, 1'b1);
        wait_drain();
    endtask

    // full store without drop, then drops including the closing transaction
    task automatic test_capacity();
        sender_idle_pct = 0;
        for (int i = 0; i < DEPTH; i++)
            send_value(random_value(), i == DEPTH - 1);
        wait_drain();
        for (int i = 0; i < DEPTH + 3; i++)
            send_value(random_value(), i == DEPTH + 2);
        send_value(random_value(), 1'b1);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int budget);
        int sent;
        int set_len;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(11) == 0)
                set_len = $urandom_range(DEPTH, 20);
            else
                set_len = $urandom_range(8, 1);
            for (int i = 0; i < set_len; i++)
                send_value(random_value(), i == set_len - 1);
            sent += set_len;
            if ($urandom_range(4) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (valid)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: value=%0d last=%0b ovf=%0b",
                                 sorted_value, last_out, overflow);
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (sorted_value !== oldest_result.sorted_value ||
                        last_out !== oldest_result.last_out ||
                        overflow !== oldest_result.overflow)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     oldest_result.sorted_value, oldest_result.last_out,
                                     oldest_result.overflow, sorted_value, last_out, overflow);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        value           = '0;
        last_in         = 1'b0;
        sending         = 1'b0;
        shadow_dropped  = 1'b0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random_traffic(14, 10);
        test_random_traffic(84, 10);
        test_random_traffic(0, 10);
        wait_drain();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ insertion_sorter_unit.f @@
src/insort_pkg.sv
src/insort_ram.sv
src/insort_ctrl.sv
src/insort_datapath.sv
src/insertion_sorter_unit.sv
tb/insertion_sorter_unit_tb.sv
